### hdl/lpr_pkg.sv
// Shared constants, register codes and the arctangent table for the lidar ROI gate.
// Used by the CORDIC step module and the top level; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package lpr_pkg;

	// Fixed widths of the datapath.
	localparam int RANGE_BITS   = 19;
	localparam int CORDIC_STEPS = 30;
	localparam int CORDIC_W     = 64;
	localparam int ACC_W        = 32;
	localparam int PRESHIFT_TOP = 58;

	// Configuration register codes (word index on the APB port).
	localparam logic [2:0] REG_ORIGIN_X   = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y   = 3'd1;
	localparam logic [2:0] REG_Z_MIN      = 3'd2;
	localparam logic [2:0] REG_Z_MAX      = 3'd3;
	localparam logic [2:0] REG_RANGE_MIN  = 3'd4;
	localparam logic [2:0] REG_RANGE_MAX  = 3'd5;
	localparam logic [2:0] REG_BEAR_CTR   = 3'd6;
	localparam logic [2:0] REG_BEAR_HALF  = 3'd7;

	// atan(2^-i) in units of 2^-32 turn.
	function automatic logic [ACC_W-1:0] atan_entry(input int unsigned i);
		logic [ACC_W-1:0] t;
		case (i)
			0: t = 32'h20000000;
			1: t = 32'h12E4051E;
			2: t = 32'h09FB385B;
			3: t = 32'h051111D4;
			4: t = 32'h028B0D43;
			5: t = 32'h0145D7E1;
			6: t = 32'h00A2F61E;
			7: t = 32'h00517C55;
			8: t = 32'h0028BE53;
			9: t = 32'h00145F2F;
			10: t = 32'h000A2F98;
			11: t = 32'h000517CC;
			12: t = 32'h00028BE6;
			13: t = 32'h000145F3;
			14: t = 32'h0000A2FA;
			15: t = 32'h0000517D;
			16: t = 32'h000028BE;
			17: t = 32'h0000145F;
			18: t = 32'h00000A30;
			19: t = 32'h00000518;
			20: t = 32'h0000028C;
			21: t = 32'h00000146;
			22: t = 32'h000000A3;
			23: t = 32'h00000051;
			24: t = 32'h00000029;
			25: t = 32'h00000014;
			26: t = 32'h0000000A;
			27: t = 32'h00000005;
			28: t = 32'h00000003;
			29: t = 32'h00000001;
			default: t = '0;
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

### hdl/lpr_pt_in_if.sv
// Input point channel: valid/ready handshake with the point payload.
// Stand-alone interface; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

interface lpr_pt_in_if #(
	parameter int COORD_BITS = 20
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;
	logic signed [COORD_BITS-1:0] point_z;
	logic                         point_finite;
	logic                         frame_last;

	modport source (
		output valid, point_x, point_y, point_z, point_finite, frame_last,
		input  ready
	);
	modport sink (
		input  valid, point_x, point_y, point_z, point_finite, frame_last,
		output ready
	);
endinterface

`default_nettype wire

### hdl/lpr_pt_out_if.sv
// Result channel: valid/ready handshake with the point and its keep flag.
// Stand-alone interface; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

interface lpr_pt_out_if #(
	parameter int COORD_BITS = 20
);
	logic                         valid;
	logic                         ready;
	logic                         keep;
	logic signed [COORD_BITS-1:0] out_x;
	logic signed [COORD_BITS-1:0] out_y;
	logic signed [COORD_BITS-1:0] out_z;
	logic                         out_last;

	modport source (
		output valid, keep, out_x, out_y, out_z, out_last,
		input  ready
	);
	modport sink (
		input  valid, keep, out_x, out_y, out_z, out_last,
		output ready
	);
endinterface

`default_nettype wire

### hdl/lpr_cordic_step.sv
// One vectoring rotation of the bearing CORDIC, fixed shift per instance.
// Depends on lpr_pkg for widths and the arctangent table.
`timescale 1ns / 1ps
`default_nettype none

module lpr_cordic_step #(
	parameter int STEP = 0
) (
	input  wire logic signed [lpr_pkg::CORDIC_W-1:0] x,
	input  wire logic signed [lpr_pkg::CORDIC_W-1:0] y,
	input  wire logic        [lpr_pkg::ACC_W-1:0]    ang,
	output logic signed      [lpr_pkg::CORDIC_W-1:0] x_next,
	output logic signed      [lpr_pkg::CORDIC_W-1:0] y_next,
	output logic             [lpr_pkg::ACC_W-1:0]    ang_next
);
	localparam logic [lpr_pkg::ACC_W-1:0] ATAN = lpr_pkg::atan_entry(STEP);

	logic signed [lpr_pkg::CORDIC_W-1:0] xs;
	logic signed [lpr_pkg::CORDIC_W-1:0] ys;

	// Arithmetic shifts round towards minus infinity.
	assign xs = x >>> STEP;
	assign ys = y >>> STEP;

	// Rotate towards the positive x axis, accumulating the angle turned.
	always_comb begin
		if (!y[lpr_pkg::CORDIC_W-1]) begin
			x_next   = x + ys;
			y_next   = y - xs;
			ang_next = ang + ATAN;
		end else begin
			x_next   = x - ys;
			y_next   = y + xs;
			ang_next = ang - ATAN;
		end
	end
endmodule

`default_nettype wire

### hdl/lidar_point_roi_gate_unit.sv
// Each accepted point yields one result beat; one beat per cycle is sustained while the output is ready.
// The depth is set by the 30-step bearing CORDIC, one rotation per pipeline stage,
// plus difference, square and bearing-compare stages; empty stages fill while the output stalls.
// Reset (arst_n low) clears all valid bits and returns the configuration registers to
// their defaults: origin 0, z in [-1000, 500], range [0, 524287], full bearing window.
`timescale 1ns / 1ps
`default_nettype none

module lidar_point_roi_gate_unit #(
	parameter int COORD_BITS = 20,
	parameter int ANGLE_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	lpr_pt_in_if.sink        pt_in,
	lpr_pt_out_if.source     pt_out,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	localparam int NCS      = lpr_pkg::CORDIC_STEPS;
	localparam int NSTG     = NCS + 3;
	localparam int LAST     = NSTG - 1;
	localparam int CW       = lpr_pkg::CORDIC_W;
	localparam int AW       = lpr_pkg::ACC_W;
	localparam int RB       = lpr_pkg::RANGE_BITS;
	localparam int DW       = COORD_BITS + 1;
	localparam int MW       = (DW > RB) ? DW : RB;
	localparam int PRESHIFT = lpr_pkg::PRESHIFT_TOP - COORD_BITS;

	// Configuration registers.
	logic signed [COORD_BITS-1:0] origin_x_q, origin_y_q, z_min_q, z_max_q;
	logic [RB-1:0]                range_min_q, range_max_q;
	logic [ANGLE_BITS-1:0]        bear_ctr_q, bear_half_q;
	logic [2*RB-1:0]              rmin2_q, rmax2_q;
	logic [2:0]                   reg_idx;

	assign reg_idx = paddr[4:2];
	assign pready  = 1'b1;

	// Register writes on the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q  <= '0;
			origin_y_q  <= '0;
			z_min_q     <= COORD_BITS'(-1000);
			z_max_q     <= COORD_BITS'(500);
			range_min_q <= '0;
			range_max_q <= '1;
			bear_ctr_q  <= '0;
			bear_half_q <= ANGLE_BITS'(1) << (ANGLE_BITS - 1);
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				lpr_pkg::REG_ORIGIN_X:  origin_x_q  <= pwdata[COORD_BITS-1:0];
				lpr_pkg::REG_ORIGIN_Y:  origin_y_q  <= pwdata[COORD_BITS-1:0];
				lpr_pkg::REG_Z_MIN:     z_min_q     <= pwdata[COORD_BITS-1:0];
				lpr_pkg::REG_Z_MAX:     z_max_q     <= pwdata[COORD_BITS-1:0];
				lpr_pkg::REG_RANGE_MIN: range_min_q <= pwdata[RB-1:0];
				lpr_pkg::REG_RANGE_MAX: range_max_q <= pwdata[RB-1:0];
				lpr_pkg::REG_BEAR_CTR:  bear_ctr_q  <= pwdata[ANGLE_BITS-1:0];
				lpr_pkg::REG_BEAR_HALF: bear_half_q <= pwdata[ANGLE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Read-back of the register values.
	always_comb begin
		case (reg_idx)
			lpr_pkg::REG_ORIGIN_X:  prdata = 32'(unsigned'(origin_x_q));
			lpr_pkg::REG_ORIGIN_Y:  prdata = 32'(unsigned'(origin_y_q));
			lpr_pkg::REG_Z_MIN:     prdata = 32'(unsigned'(z_min_q));
			lpr_pkg::REG_Z_MAX:     prdata = 32'(unsigned'(z_max_q));
			lpr_pkg::REG_RANGE_MIN: prdata = 32'(range_min_q);
			lpr_pkg::REG_RANGE_MAX: prdata = 32'(range_max_q);
			lpr_pkg::REG_BEAR_CTR:  prdata = 32'(bear_ctr_q);
			lpr_pkg::REG_BEAR_HALF: prdata = 32'(bear_half_q);
			default:                prdata = '0;
		endcase
	end

	// Squared range limits, refreshed every cycle from the registers.
	always_ff @(posedge clk) begin
		rmin2_q <= range_min_q * range_min_q;
		rmax2_q <= range_max_q * range_max_q;
	end

	// Pipeline control: a stage moves when it is empty or its successor moves.
	logic [NSTG-1:0] vld_s;
	logic [NSTG-1:0] adv;

	always_comb begin
		adv[LAST] = !vld_s[LAST] || pt_out.ready;
		for (int k = LAST - 1; k >= 0; k--) begin
			adv[k] = !vld_s[k] || adv[k+1];
		end
	end

	assign pt_in.ready = adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[0]) begin
				vld_s[0] <= pt_in.valid;
			end
			for (int k = 1; k < NSTG; k++) begin
				if (adv[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// Point fields travel unchanged alongside the computation.
	logic signed [COORD_BITS-1:0] px_s [NSTG];
	logic signed [COORD_BITS-1:0] py_s [NSTG];
	logic signed [COORD_BITS-1:0] pz_s [NSTG];
	logic                         last_s [NSTG];

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			px_s[0]   <= pt_in.point_x;
			py_s[0]   <= pt_in.point_y;
			pz_s[0]   <= pt_in.point_z;
			last_s[0] <= pt_in.frame_last;
		end
		for (int k = 1; k < NSTG; k++) begin
			if (adv[k]) begin
				px_s[k]   <= px_s[k-1];
				py_s[k]   <= py_s[k-1];
				pz_s[k]   <= pz_s[k-1];
				last_s[k] <= last_s[k-1];
			end
		end
	end

	// Stage 1: offsets from the origin and the height test.
	logic signed [DW-1:0] dx_s1, dy_s1;
	logic                 kz_s1;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			dx_s1 <= DW'(pt_in.point_x) - DW'(origin_x_q);
			dy_s1 <= DW'(pt_in.point_y) - DW'(origin_y_q);
			kz_s1 <= pt_in.point_finite && (pt_in.point_z >= z_min_q)
				&& (pt_in.point_z <= z_max_q);
		end
	end

	// Stage 2: magnitudes, far test, squares and CORDIC start vector.
	logic [DW-1:0]        ax, ay;
	logic [MW-1:0]        ax_m, ay_m;
	logic signed [CW-1:0] dx_w, dy_w;
	logic [2*RB-1:0]      sqx_s2, sqy_s2;
	logic                 kz_s2, far_s2;
	logic signed [CW-1:0] cx_s [1:NCS+1];
	logic signed [CW-1:0] cy_s [1:NCS+1];
	logic [AW-1:0]        ca_s [1:NCS+1];
	logic                 zero_s [1:NCS+1];

	assign ax   = dx_s1[DW-1] ? DW'(-dx_s1) : DW'(dx_s1);
	assign ay   = dy_s1[DW-1] ? DW'(-dy_s1) : DW'(dy_s1);
	assign ax_m = MW'(ax);
	assign ay_m = MW'(ay);
	assign dx_w = CW'(dx_s1);
	assign dy_w = CW'(dy_s1);

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			far_s2    <= (ax_m > MW'(range_max_q)) || (ay_m > MW'(range_max_q));
			sqx_s2    <= ax_m[RB-1:0] * ax_m[RB-1:0];
			sqy_s2    <= ay_m[RB-1:0] * ay_m[RB-1:0];
			kz_s2     <= kz_s1;
			zero_s[1] <= (dx_s1 == '0) && (dy_s1 == '0);
			// A vector pointing left is mirrored and starts at a half turn.
			if (dx_s1[DW-1]) begin
				cx_s[1] <= (-dx_w) <<< PRESHIFT;
				cy_s[1] <= (-dy_w) <<< PRESHIFT;
				ca_s[1] <= AW'(1) << (AW - 1);
			end else begin
				cx_s[1] <= dx_w <<< PRESHIFT;
				cy_s[1] <= dy_w <<< PRESHIFT;
				ca_s[1] <= '0;
			end
		end
	end

	// Stage 3: squared range against the limits.
	logic [2*RB:0] r2;
	logic          kpre_s [2:LAST-1];

	assign r2 = (2*RB+1)'(sqx_s2) + (2*RB+1)'(sqy_s2);

	// The early keep decision is then carried down to the bearing stage.
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			kpre_s[2] <= kz_s2 && !far_s2 && (r2 >= (2*RB+1)'(rmin2_q))
				&& (r2 <= (2*RB+1)'(rmax2_q));
		end
		for (int k = 3; k < LAST; k++) begin
			if (adv[k]) begin
				kpre_s[k] <= kpre_s[k-1];
			end
		end
	end

	// CORDIC rotations, one per stage.
	for (genvar i = 0; i < NCS; i++) begin : g_cordic
		logic signed [CW-1:0] xn, yn;
		logic [AW-1:0]        an;

		lpr_cordic_step #(.STEP(i)) u_step (
			.x        (cx_s[i+1]),
			.y        (cy_s[i+1]),
			.ang      (ca_s[i+1]),
			.x_next   (xn),
			.y_next   (yn),
			.ang_next (an)
		);

		always_ff @(posedge clk) begin
			if (adv[i+2]) begin
				cx_s[i+2]   <= xn;
				cy_s[i+2]   <= yn;
				ca_s[i+2]   <= an;
				zero_s[i+2] <= zero_s[i+1];
			end
		end
	end

	// Last stage: rounded bearing, wrapped deviation and final keep.
	logic [AW-1:0]         ang_rnd;
	logic [ANGLE_BITS-1:0] bear, diff;
	logic [ANGLE_BITS:0]   dev;
	logic                  keep_s;

	assign ang_rnd = ca_s[NCS+1] + (AW'(1) << (AW - 1 - ANGLE_BITS));
	assign bear    = zero_s[NCS+1] ? '0 : ang_rnd[AW-1 -: ANGLE_BITS];
	assign diff    = bear - bear_ctr_q;
	assign dev     = diff[ANGLE_BITS-1] ? ((ANGLE_BITS+1)'(1) << ANGLE_BITS)
		- (ANGLE_BITS+1)'(diff) : (ANGLE_BITS+1)'(diff);

	always_ff @(posedge clk) begin
		if (adv[LAST]) begin
			keep_s <= kpre_s[LAST-1] && (dev <= (ANGLE_BITS+1)'(bear_half_q));
		end
	end

	// Result beat.
	assign pt_out.valid    = vld_s[LAST];
	assign pt_out.keep     = keep_s;
	assign pt_out.out_x    = px_s[LAST];
	assign pt_out.out_y    = py_s[LAST];
	assign pt_out.out_z    = pz_s[LAST];
	assign pt_out.out_last = last_s[LAST];
endmodule

`default_nettype wire
